[rtl/bvm_pkg.sv]
// Package for the bytecode VM instruction core: item and result types,
// sequencer states, shared ALU codes, instruction constants and the font.
// No dependencies.
`default_nettype none
package bvm_pkg;

	localparam int MEM_AW  = 12;
	localparam int DISP_AW = 8;
	localparam int VREG_AW = 4;
	localparam int MEM_BYTES  = 4096;
	localparam int DISP_BYTES = 256;
	localparam int VREG_COUNT = 16;
	localparam int FONT_BYTES = 80;

	// item opcodes
	localparam logic [1:0] OP_WRITE  = 2'd0;
	localparam logic [1:0] OP_EXEC   = 2'd1;
	localparam logic [1:0] OP_READ   = 2'd2;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// whole instructions and sub-codes
	localparam logic [15:0] INS_CLS = 16'h00E0;
	localparam logic [15:0] INS_RET = 16'h00EE;
	localparam logic [7:0]  KK_SKP  = 8'h9E;
	localparam logic [7:0]  KK_SKNP = 8'hA1;
	localparam logic [7:0]  KK_LDDT = 8'h07;
	localparam logic [7:0]  KK_WKEY = 8'h0A;
	localparam logic [7:0]  KK_STDT = 8'h15;
	localparam logic [7:0]  KK_STST = 8'h18;
	localparam logic [7:0]  KK_ADDI = 8'h1E;
	localparam logic [7:0]  KK_FONT = 8'h29;
	localparam logic [7:0]  KK_BCD  = 8'h33;
	localparam logic [7:0]  KK_STOR = 8'h55;
	localparam logic [7:0]  KK_LOAD = 8'h65;
	localparam logic [3:0]  N_LD   = 4'h0;
	localparam logic [3:0]  N_OR   = 4'h1;
	localparam logic [3:0]  N_AND  = 4'h2;
	localparam logic [3:0]  N_XOR  = 4'h3;
	localparam logic [3:0]  N_ADD  = 4'h4;
	localparam logic [3:0]  N_SUB  = 4'h5;
	localparam logic [3:0]  N_SHR  = 4'h6;
	localparam logic [3:0]  N_SUBN = 4'h7;
	localparam logic [3:0]  N_SHL  = 4'hE;
	localparam logic [3:0]  VF_IDX = 4'hF;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [11:0] address;
		logic [7:0]  data;
		logic [15:0] key_states;
		logic [7:0]  random_byte;
	} cmd_t;

	typedef struct packed {
		logic [11:0] program_counter;
		logic [15:0] executed_instruction;
		logic [7:0]  read_data;
		logic        key_wait;
		logic        sprite_collision;
		logic        sound_on;
		logic        unknown_instruction;
	} rsp_t;

	typedef enum logic [2:0] {
		ALU_PASS, ALU_OR, ALU_AND, ALU_XOR, ALU_ADD, ALU_SUB, ALU_SHR, ALU_SHL
	} alu_op_t;

	typedef struct packed {
		logic [7:0] res;
		logic       flag;
		logic       eq;
		logic       ge;
	} alu_res_t;

	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE, S_RD_A, S_RD_D, S_F0, S_F1, S_F2, S_F3, S_F4, S_EXEC,
		S_WF, S_CLS, S_DR0, S_DR1, S_DR2, S_DR3, S_BCD_H, S_BCD_T, S_BCD_W0,
		S_BCD_W1, S_BCD_W2, S_ST0, S_ST1, S_LD0, S_LD1, S_TICK, S_DONE
	} state_t;

	localparam logic [7:0] GLYPHS [FONT_BYTES] = '{
		8'hf0, 8'h90, 8'h90, 8'h90, 8'hf0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
		8'hf0, 8'h10, 8'hf0, 8'h80, 8'hf0, 8'hf0, 8'h10, 8'hf0, 8'h10, 8'hf0,
		8'h90, 8'h90, 8'hf0, 8'h10, 8'h10, 8'hf0, 8'h80, 8'hf0, 8'h10, 8'hf0,
		8'hf0, 8'h80, 8'hf0, 8'h90, 8'hf0, 8'hf0, 8'h10, 8'h20, 8'h40, 8'h40,
		8'hf0, 8'h90, 8'hf0, 8'h90, 8'hf0, 8'hf0, 8'h90, 8'hf0, 8'h10, 8'hf0,
		8'hf0, 8'h90, 8'hf0, 8'h90, 8'h90, 8'he0, 8'h90, 8'he0, 8'h90, 8'he0,
		8'hf0, 8'h80, 8'h80, 8'h80, 8'hf0, 8'he0, 8'h90, 8'h90, 8'h90, 8'he0,
		8'hf0, 8'h80, 8'hf0, 8'h80, 8'hf0, 8'hf0, 8'h80, 8'hf0, 8'h80, 8'h80
	};

	function automatic logic [7:0] glyph(input logic [6:0] i);
		glyph = (i < 7'(FONT_BYTES)) ? GLYPHS[i] : 8'h00;
	endfunction

endpackage
`default_nettype wire

[rtl/bvm_chan_if.sv]
// Valid/ready channel carrying one request or result payload.
// Payload type is set by the type parameter T; no dependencies.
`default_nettype none
interface bvm_chan_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface
`default_nettype wire

[rtl/bvm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module bvm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

[rtl/bvm_alu.sv]
// Shared 8-bit ALU: logic ops, add/sub with flag, shifts, compares.
// Depends on bvm_pkg.
`default_nettype none
module bvm_alu (
	input  wire bvm_pkg::alu_op_t  op,
	input  wire logic [7:0]        a,
	input  wire logic [7:0]        b,
	output bvm_pkg::alu_res_t      y
);
	logic [8:0] sum;

	assign sum = {1'b0, a} + {1'b0, b};

	always_comb begin
		y.eq   = (a == b);
		y.ge   = (a >= b);
		y.flag = 1'b0;
		case (op)
			bvm_pkg::ALU_PASS: y.res = b;
			bvm_pkg::ALU_OR:   y.res = a | b;
			bvm_pkg::ALU_AND:  y.res = a & b;
			bvm_pkg::ALU_XOR:  y.res = a ^ b;
			bvm_pkg::ALU_ADD: begin
				y.res  = sum[7:0];
				y.flag = sum[8];
			end
			bvm_pkg::ALU_SUB: begin
				y.res  = a - b;
				y.flag = (a > b);
			end
			bvm_pkg::ALU_SHR: begin
				y.res  = {1'b0, a[7:1]};
				y.flag = a[0];
			end
			bvm_pkg::ALU_SHL: begin
				y.res  = {a[6:0], 1'b0};
				y.flag = a[7];
			end
			default: y.res = b;
		endcase
	end
endmodule
`default_nettype wire

[rtl/bytecode_vm_instruction_core_unit.sv]
// Top level of the bytecode VM instruction core (CHIP-8 style interpreter).
// Depends on bvm_pkg, bvm_chan_if, bvm_ram and bvm_alu.
`default_nettype none
// One request at a time: a request is taken only while the sequencer is idle,
// and the result sits in an output register so the next request can be taken
// while it waits. After reset a clearing pass loads the font and zeroes memory,
// display and registers; no request is taken meanwhile.
module bytecode_vm_instruction_core_unit #(
	parameter int FONT_BASE     = 80,
	parameter int PROGRAM_START = 512
) (
	input wire logic clk,
	input wire logic arst_n,
	bvm_chan_if.sink   cmd,
	bvm_chan_if.source rsp
);
	localparam logic [11:0] FONT_ADDR = 12'(FONT_BASE);
	localparam logic [11:0] PC_START  = 12'(PROGRAM_START);
	localparam logic [11:0] MEM_LAST  = 12'(bvm_pkg::MEM_BYTES - 1);

	bvm_pkg::state_t state_q, state_d;
	bvm_pkg::cmd_t   item_q, item_d;
	bvm_pkg::rsp_t   out_q, out_d;
	logic            out_valid_q, out_valid_d;
	logic [11:0] pc_q, pc_d, clr_q, clr_d;
	logic [15:0] idx_q, idx_d, instr_q, instr_d;
	logic [3:0]  sp_q, sp_d, cnt_q, cnt_d;
	logic [7:0]  delay_q, delay_d, sound_q, sound_d;
	logic [7:0]  hi_q, hi_d, vx_q, vx_d, vy_q, vy_d, spr_q, spr_d;
	logic [7:0]  rem_q, rem_d, dig_h_q, dig_h_d, dig_t_q, dig_t_d, rd_q, rd_d;
	logic        flag_q, flag_d, hit_q, hit_d, kwait_q, kwait_d;
	logic        coll_q, coll_d, unk_q, unk_d;
	logic [11:0] stack_q [bvm_pkg::VREG_COUNT];
	logic        stk_we;

	// memory ports
	logic                        mem_we, disp_we, vreg_we;
	logic [bvm_pkg::MEM_AW-1:0]  mem_waddr, mem_raddr;
	logic [bvm_pkg::DISP_AW-1:0] disp_waddr, disp_raddr;
	logic [bvm_pkg::VREG_AW-1:0] vreg_waddr, vreg_raddr;
	logic [7:0] mem_wdata, mem_rdata, disp_wdata, disp_rdata, vreg_wdata, vreg_rdata;

	bvm_pkg::alu_op_t  alu_op;
	logic [7:0]        alu_a, alu_b;
	bvm_pkg::alu_res_t alu_y;

	// decoded fields and draw geometry
	logic [3:0]  f_x, f_y, f_n, f_top, key_lo;
	logic [7:0]  f_kk;
	logic [11:0] f_nnn, font_off, idx_addr;
	logic [4:0]  row;
	logic [2:0]  cb;
	logic [15:0] shifted;
	logic        key_hit, hit_new;

	bvm_ram #(.WIDTH(8), .DEPTH(bvm_pkg::MEM_BYTES)) u_mem (
		.clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
		.raddr(mem_raddr), .rdata(mem_rdata)
	);
	bvm_ram #(.WIDTH(8), .DEPTH(bvm_pkg::DISP_BYTES)) u_disp (
		.clk(clk), .we(disp_we), .waddr(disp_waddr), .wdata(disp_wdata),
		.raddr(disp_raddr), .rdata(disp_rdata)
	);
	bvm_ram #(.WIDTH(8), .DEPTH(bvm_pkg::VREG_COUNT)) u_vreg (
		.clk(clk), .we(vreg_we), .waddr(vreg_waddr), .wdata(vreg_wdata),
		.raddr(vreg_raddr), .rdata(vreg_rdata)
	);
	bvm_alu u_alu (.op(alu_op), .a(alu_a), .b(alu_b), .y(alu_y));

	// lowest pressed key
	function automatic logic [3:0] lowest_key(input logic [15:0] k);
		logic [3:0] r;
		r = 4'd0;
		for (int i = 15; i >= 0; i--) begin
			if (k[i]) begin
				r = 4'(i);
			end
		end
		return r;
	endfunction

	assign f_top    = instr_q[15:12];
	assign f_x      = instr_q[11:8];
	assign f_y      = instr_q[7:4];
	assign f_n      = instr_q[3:0];
	assign f_kk     = instr_q[7:0];
	assign f_nnn    = instr_q[11:0];
	assign font_off = clr_q - FONT_ADDR;
	assign idx_addr = idx_q[11:0];
	assign row      = vy_q[4:0] + {1'b0, cnt_q};
	assign cb       = vx_q[5:3];
	assign shifted  = {spr_q, 8'h00} >> vx_q[2:0];
	assign key_lo   = vx_q[3:0];
	assign key_hit  = item_q.key_states[key_lo];

	assign cmd.ready   = (state_q == bvm_pkg::S_IDLE);
	assign rsp.valid   = out_valid_q;
	assign rsp.payload = out_q;

	// sequencer: next state, datapath updates and memory ports
	always_comb begin
		state_d = state_q;   item_d = item_q;   out_d = out_q;
		out_valid_d = out_valid_q;
		pc_d = pc_q;   clr_d = clr_q;   idx_d = idx_q;   instr_d = instr_q;
		sp_d = sp_q;   cnt_d = cnt_q;   delay_d = delay_q;   sound_d = sound_q;
		hi_d = hi_q;   vx_d = vx_q;   vy_d = vy_q;   spr_d = spr_q;
		rem_d = rem_q;   dig_h_d = dig_h_q;   dig_t_d = dig_t_q;   rd_d = rd_q;
		flag_d = flag_q;   hit_d = hit_q;   kwait_d = kwait_q;
		coll_d = coll_q;   unk_d = unk_q;
		stk_we = 1'b0;
		mem_we = 1'b0;   mem_waddr = '0;   mem_wdata = '0;   mem_raddr = '0;
		disp_we = 1'b0;  disp_waddr = '0;  disp_wdata = '0;  disp_raddr = '0;
		vreg_we = 1'b0;  vreg_waddr = '0;  vreg_wdata = '0;  vreg_raddr = '0;
		alu_op = bvm_pkg::ALU_PASS;   alu_a = vx_q;   alu_b = vy_q;
		hit_new = hit_q;

		if (rsp.ready) begin
			out_valid_d = 1'b0;
		end

		case (state_q)
			bvm_pkg::S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = (clr_q >= FONT_ADDR && font_off < 12'(bvm_pkg::FONT_BYTES))
					? bvm_pkg::glyph(font_off[6:0]) : 8'h00;
				disp_we    = (clr_q[11:8] == 4'd0);
				disp_waddr = clr_q[7:0];
				vreg_we    = (clr_q[11:4] == 8'd0);
				vreg_waddr = clr_q[3:0];
				clr_d = clr_q + 12'd1;
				if (clr_q == MEM_LAST) begin
					state_d = bvm_pkg::S_IDLE;
				end
			end
			bvm_pkg::S_IDLE: begin
				if (cmd.valid) begin
					item_d = cmd.payload;
					rd_d = 8'h00;   kwait_d = 1'b0;   coll_d = 1'b0;   unk_d = 1'b0;
					case (cmd.payload.opcode)
						bvm_pkg::OP_WRITE: begin
							mem_we    = 1'b1;
							mem_waddr = cmd.payload.address;
							mem_wdata = cmd.payload.data;
							state_d   = bvm_pkg::S_DONE;
						end
						bvm_pkg::OP_EXEC: state_d = bvm_pkg::S_F0;
						bvm_pkg::OP_READ: state_d = bvm_pkg::S_RD_A;
						default:          state_d = bvm_pkg::S_DONE;
					endcase
				end
			end
			bvm_pkg::S_RD_A: begin
				mem_raddr  = item_q.address;
				disp_raddr = item_q.address[7:0];
				state_d    = bvm_pkg::S_RD_D;
			end
			bvm_pkg::S_RD_D: begin
				rd_d    = item_q.address[11] ? disp_rdata : mem_rdata;
				state_d = bvm_pkg::S_DONE;
			end
			// fetch two bytes, then read Vx, Vy and V0
			bvm_pkg::S_F0: begin
				mem_raddr = pc_q;
				state_d   = bvm_pkg::S_F1;
			end
			bvm_pkg::S_F1: begin
				hi_d      = mem_rdata;
				mem_raddr = pc_q + 12'd1;
				state_d   = bvm_pkg::S_F2;
			end
			bvm_pkg::S_F2: begin
				instr_d    = {hi_q, mem_rdata};
				pc_d       = pc_q + 12'd2;
				vreg_raddr = hi_q[3:0];
				state_d    = bvm_pkg::S_F3;
			end
			bvm_pkg::S_F3: begin
				vx_d       = vreg_rdata;
				vreg_raddr = f_y;
				state_d    = bvm_pkg::S_F4;
			end
			bvm_pkg::S_F4: begin
				vy_d       = vreg_rdata;
				vreg_raddr = 4'd0;
				state_d    = bvm_pkg::S_EXEC;
			end
			bvm_pkg::S_EXEC: begin
				state_d    = bvm_pkg::S_TICK;
				vreg_waddr = f_x;
				case (f_top)
					4'h0: begin
						if (instr_q == bvm_pkg::INS_CLS) begin
							clr_d   = 12'd0;
							state_d = bvm_pkg::S_CLS;
						end else if (instr_q == bvm_pkg::INS_RET) begin
							sp_d = sp_q - 4'd1;
							pc_d = stack_q[sp_q - 4'd1];
						end else begin
							unk_d = 1'b1;
						end
					end
					4'h1: pc_d = f_nnn;
					4'h2: begin
						stk_we = 1'b1;
						sp_d   = sp_q + 4'd1;
						pc_d   = f_nnn;
					end
					4'h3, 4'h4: begin
						alu_b = f_kk;
						if (alu_y.eq == (f_top == 4'h3)) begin
							pc_d = pc_q + 12'd2;
						end
					end
					4'h5, 4'h9: begin
						if (alu_y.eq == (f_top == 4'h5)) begin
							pc_d = pc_q + 12'd2;
						end
					end
					4'h6: begin
						vreg_we    = 1'b1;
						vreg_wdata = f_kk;
					end
					4'h7: begin
						alu_op     = bvm_pkg::ALU_ADD;
						alu_b      = f_kk;
						vreg_we    = 1'b1;
						vreg_wdata = alu_y.res;
					end
					4'h8: begin
						vreg_we    = 1'b1;
						vreg_wdata = alu_y.res;
						flag_d     = alu_y.flag;
						state_d    = bvm_pkg::S_WF;
						case (f_n)
							bvm_pkg::N_LD: begin
								alu_op  = bvm_pkg::ALU_PASS;
								state_d = bvm_pkg::S_TICK;
							end
							bvm_pkg::N_OR: begin
								alu_op  = bvm_pkg::ALU_OR;
								state_d = bvm_pkg::S_TICK;
							end
							bvm_pkg::N_AND: begin
								alu_op  = bvm_pkg::ALU_AND;
								state_d = bvm_pkg::S_TICK;
							end
							bvm_pkg::N_XOR: begin
								alu_op  = bvm_pkg::ALU_XOR;
								state_d = bvm_pkg::S_TICK;
							end
							bvm_pkg::N_ADD: alu_op = bvm_pkg::ALU_ADD;
							bvm_pkg::N_SUB: alu_op = bvm_pkg::ALU_SUB;
							bvm_pkg::N_SHR: alu_op = bvm_pkg::ALU_SHR;
							bvm_pkg::N_SUBN: begin
								alu_op = bvm_pkg::ALU_SUB;
								alu_a  = vy_q;
								alu_b  = vx_q;
							end
							bvm_pkg::N_SHL: alu_op = bvm_pkg::ALU_SHL;
							default: begin
								vreg_we = 1'b0;
								flag_d  = flag_q;
								unk_d   = 1'b1;
								state_d = bvm_pkg::S_TICK;
							end
						endcase
					end
					4'hA: idx_d = {4'h0, f_nnn};
					4'hB: pc_d = f_nnn + {4'h0, vreg_rdata};
					4'hC: begin
						vreg_we    = 1'b1;
						vreg_wdata = item_q.random_byte & f_kk;
					end
					4'hD: begin
						hit_d = 1'b0;
						cnt_d = 4'd0;
						if (f_n == 4'd0) begin
							flag_d  = 1'b0;
							state_d = bvm_pkg::S_WF;
						end else begin
							state_d = bvm_pkg::S_DR0;
						end
					end
					4'hE: begin
						if (f_kk == bvm_pkg::KK_SKP) begin
							if (key_hit) begin
								pc_d = pc_q + 12'd2;
							end
						end else if (f_kk == bvm_pkg::KK_SKNP) begin
							if (!key_hit) begin
								pc_d = pc_q + 12'd2;
							end
						end else begin
							unk_d = 1'b1;
						end
					end
					default: begin
						case (f_kk)
							bvm_pkg::KK_LDDT: begin
								vreg_we    = 1'b1;
								vreg_wdata = delay_q;
							end
							bvm_pkg::KK_WKEY: begin
								if (item_q.key_states == 16'h0000) begin
									pc_d    = pc_q - 12'd2;
									kwait_d = 1'b1;
								end else begin
									vreg_we    = 1'b1;
									vreg_wdata = {4'h0, lowest_key(item_q.key_states)};
								end
							end
							bvm_pkg::KK_STDT: delay_d = vx_q;
							bvm_pkg::KK_STST: sound_d = vx_q;
							bvm_pkg::KK_ADDI: idx_d = idx_q + {8'h00, vx_q};
							bvm_pkg::KK_FONT: idx_d = {4'h0, FONT_ADDR}
								+ {10'd0, key_lo, 2'b00} + {12'd0, key_lo};
							bvm_pkg::KK_BCD: begin
								rem_d   = vx_q;
								dig_h_d = 8'h00;
								dig_t_d = 8'h00;
								state_d = bvm_pkg::S_BCD_H;
							end
							bvm_pkg::KK_STOR: begin
								cnt_d   = 4'd0;
								state_d = bvm_pkg::S_ST0;
							end
							bvm_pkg::KK_LOAD: begin
								cnt_d   = 4'd0;
								state_d = bvm_pkg::S_LD0;
							end
							default: unk_d = 1'b1;
						endcase
					end
				endcase
			end
			// flag register written last so it wins over Vx
			bvm_pkg::S_WF: begin
				vreg_we    = 1'b1;
				vreg_waddr = bvm_pkg::VF_IDX;
				vreg_wdata = {7'd0, flag_q};
				state_d    = bvm_pkg::S_TICK;
			end
			bvm_pkg::S_CLS: begin
				disp_we    = 1'b1;
				disp_waddr = clr_q[7:0];
				clr_d      = clr_q + 12'd1;
				if (clr_q[7:0] == 8'hFF) begin
					state_d = bvm_pkg::S_TICK;
				end
			end
			// sprite row: fetch byte, then XOR into two display bytes
			bvm_pkg::S_DR0: begin
				mem_raddr = idx_addr + {8'h00, cnt_q};
				state_d   = bvm_pkg::S_DR1;
			end
			bvm_pkg::S_DR1: begin
				spr_d      = mem_rdata;
				disp_raddr = {row, cb};
				state_d    = bvm_pkg::S_DR2;
			end
			bvm_pkg::S_DR2: begin
				disp_we    = 1'b1;
				disp_waddr = {row, cb};
				disp_wdata = disp_rdata ^ shifted[15:8];
				hit_d      = hit_q | (|(disp_rdata & shifted[15:8]));
				disp_raddr = {row, cb + 3'd1};
				state_d    = bvm_pkg::S_DR3;
			end
			bvm_pkg::S_DR3: begin
				disp_we    = 1'b1;
				disp_waddr = {row, cb + 3'd1};
				disp_wdata = disp_rdata ^ shifted[7:0];
				hit_new    = hit_q | (|(disp_rdata & shifted[7:0]));
				hit_d      = hit_new;
				cnt_d      = cnt_q + 4'd1;
				if (cnt_q == f_n - 4'd1) begin
					flag_d  = hit_new;
					coll_d  = hit_new;
					state_d = bvm_pkg::S_WF;
				end else begin
					state_d = bvm_pkg::S_DR0;
				end
			end
			// decimal digits by repeated subtraction on the ALU
			bvm_pkg::S_BCD_H: begin
				alu_op = bvm_pkg::ALU_SUB;
				alu_a  = rem_q;
				alu_b  = 8'd100;
				if (alu_y.ge) begin
					rem_d   = alu_y.res;
					dig_h_d = dig_h_q + 8'd1;
				end else begin
					state_d = bvm_pkg::S_BCD_T;
				end
			end
			bvm_pkg::S_BCD_T: begin
				alu_op = bvm_pkg::ALU_SUB;
				alu_a  = rem_q;
				alu_b  = 8'd10;
				if (alu_y.ge) begin
					rem_d   = alu_y.res;
					dig_t_d = dig_t_q + 8'd1;
				end else begin
					state_d = bvm_pkg::S_BCD_W0;
				end
			end
			bvm_pkg::S_BCD_W0: begin
				mem_we    = 1'b1;
				mem_waddr = idx_addr;
				mem_wdata = dig_h_q;
				state_d   = bvm_pkg::S_BCD_W1;
			end
			bvm_pkg::S_BCD_W1: begin
				mem_we    = 1'b1;
				mem_waddr = idx_addr + 12'd1;
				mem_wdata = dig_t_q;
				state_d   = bvm_pkg::S_BCD_W2;
			end
			bvm_pkg::S_BCD_W2: begin
				mem_we    = 1'b1;
				mem_waddr = idx_addr + 12'd2;
				mem_wdata = rem_q;
				state_d   = bvm_pkg::S_TICK;
			end
			// V0..Vx to memory
			bvm_pkg::S_ST0: begin
				vreg_raddr = cnt_q;
				state_d    = bvm_pkg::S_ST1;
			end
			bvm_pkg::S_ST1: begin
				mem_we    = 1'b1;
				mem_waddr = idx_addr + {8'h00, cnt_q};
				mem_wdata = vreg_rdata;
				cnt_d     = cnt_q + 4'd1;
				state_d   = (cnt_q == f_x) ? bvm_pkg::S_TICK : bvm_pkg::S_ST0;
			end
			// memory to V0..Vx
			bvm_pkg::S_LD0: begin
				mem_raddr = idx_addr + {8'h00, cnt_q};
				state_d   = bvm_pkg::S_LD1;
			end
			bvm_pkg::S_LD1: begin
				vreg_we    = 1'b1;
				vreg_waddr = cnt_q;
				vreg_wdata = mem_rdata;
				cnt_d      = cnt_q + 4'd1;
				state_d    = (cnt_q == f_x) ? bvm_pkg::S_TICK : bvm_pkg::S_LD0;
			end
			bvm_pkg::S_TICK: begin
				if (delay_q != 8'h00) begin
					delay_d = delay_q - 8'd1;
				end
				if (sound_q != 8'h00) begin
					sound_d = sound_q - 8'd1;
				end
				state_d = bvm_pkg::S_DONE;
			end
			bvm_pkg::S_DONE: begin
				if (!out_valid_q || rsp.ready) begin
					out_d.program_counter      = pc_q;
					out_d.executed_instruction =
						(item_q.opcode == bvm_pkg::OP_EXEC) ? instr_q : 16'h0000;
					out_d.read_data            = rd_q;
					out_d.key_wait             = kwait_q;
					out_d.sprite_collision     = coll_q;
					out_d.sound_on             = (sound_q != 8'h00);
					out_d.unknown_instruction  = unk_q;
					out_valid_d                = 1'b1;
					state_d                    = bvm_pkg::S_IDLE;
				end
			end
			default: state_d = bvm_pkg::S_IDLE;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bvm_pkg::S_CLEAR;
			out_valid_q <= 1'b0;
			pc_q        <= PC_START;
			clr_q       <= 12'd0;
			idx_q       <= 16'h0000;
			sp_q        <= 4'd0;
			delay_q     <= 8'h00;
			sound_q     <= 8'h00;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
			pc_q        <= pc_d;
			clr_q       <= clr_d;
			idx_q       <= idx_d;
			sp_q        <= sp_d;
			delay_q     <= delay_d;
			sound_q     <= sound_d;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		item_q  <= item_d;   out_q   <= out_d;   instr_q <= instr_d;
		cnt_q   <= cnt_d;    hi_q    <= hi_d;    vx_q    <= vx_d;
		vy_q    <= vy_d;     spr_q   <= spr_d;   rem_q   <= rem_d;
		dig_h_q <= dig_h_d;  dig_t_q <= dig_t_d; rd_q    <= rd_d;
		flag_q  <= flag_d;   hit_q   <= hit_d;   kwait_q <= kwait_d;
		coll_q  <= coll_d;   unk_q   <= unk_d;
		if (stk_we) begin
			stack_q[sp_q] <= pc_q;
		end
	end

`ifndef SYNTH
	// an accepted request keeps the block busy the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid && cmd.ready |=> !cmd.ready)
		else $error("request accepted while previous one in flight");

	// a new result only comes from the result-hand-off state
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> $past(state_q) == bvm_pkg::S_DONE)
		else $error("result raised outside hand-off");

	// sprite row counter stays below the row count
	a_draw_rows: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == bvm_pkg::S_DR3 |-> cnt_q < f_n)
		else $error("sprite row counter overran");
`endif
endmodule
`default_nettype wire

[tb/bytecode_vm_instruction_core_unit_tb.sv]
// Testbench for the bytecode VM instruction core: drives program loads, reads and
// instruction steps, and checks every result against an in-bench CHIP-8 predictor.
// Depends on bvm_pkg, bvm_chan_if and the core RTL.
`timescale 1ns / 100ps
`default_nettype none
module bytecode_vm_instruction_core_unit_tb;

	localparam int FONT_AT  = 80;
	localparam int PROG_AT  = 512;
	localparam int CYC_MAX  = 2000000;

	logic clk;
	logic arst_n;
	bvm_chan_if #(.T(bvm_pkg::cmd_t)) cmd_ch ();
	bvm_chan_if #(.T(bvm_pkg::rsp_t)) rsp_ch ();

	bytecode_vm_instruction_core_unit #(.FONT_BASE(FONT_AT), .PROGRAM_START(PROG_AT)) dut (
		.clk(clk), .arst_n(arst_n), .cmd(cmd_ch.sink), .rsp(rsp_ch.source)
	);

	// predictor state
	logic [7:0]  vreg [16];
	logic [15:0] ireg;
	logic [11:0] pc;
	logic [11:0] ret_stack [16];
	logic [3:0]  sp;
	logic [7:0]  mem [bvm_pkg::MEM_BYTES];
	logic        pix [2048];
	logic [7:0]  dtimer, stimer;

	bvm_pkg::cmd_t pending_reqs [$];
	bvm_pkg::rsp_t expected_rsps [$];
	int   errors, checked, cycles, sent;
	int   send_idle_pct, recv_idle_pct;
	bit   hold_send, stim_done;
	logic req_acc;

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	task automatic report(input string what, input logic [15:0] got, input logic [15:0] exp);
		$display("mismatch %0s: got %0h expected %0h (result %0d)", what, got, exp, checked);
		errors++;
	endtask

	function automatic void vm_reset();
		for (int k = 0; k < 16; k++) begin
			vreg[k] = 0;
			ret_stack[k] = 0;
		end
		for (int k = 0; k < bvm_pkg::MEM_BYTES; k++) mem[k] = 0;
		for (int k = 0; k < 80; k++) mem[FONT_AT + k] = bvm_pkg::GLYPHS[k];
		for (int k = 0; k < 2048; k++) pix[k] = 0;
		ireg = 0;
		pc = PROG_AT;
		sp = 0;
		dtimer = 0;
		stimer = 0;
	endfunction

	// compute the result of one request and update the machine image
	function automatic bvm_pkg::rsp_t vm_step(input bvm_pkg::cmd_t c);
		bvm_pkg::rsp_t r;
		logic [15:0] ins;
		logic [3:0] x, y, n;
		logic [7:0] kk, vx, vy, f, bits, v;
		logic [11:0] nnn;
		logic hit;
		int px, py, row, col;
		r = '0;
		if (c.opcode == bvm_pkg::OP_WRITE) begin
			mem[c.address] = c.data;
		end else if (c.opcode == bvm_pkg::OP_READ) begin
			if (c.address[11]) begin
				row = c.address[7:3];
				col = c.address[2:0] * 8;
				v = 0;
				for (int b = 0; b < 8; b++) v = {v[6:0], pix[row * 64 + col + b]};
				r.read_data = v;
			end else begin
				r.read_data = mem[c.address];
			end
		end else if (c.opcode == bvm_pkg::OP_EXEC) begin
			ins = {mem[pc], mem[12'(pc + 1)]};
			r.executed_instruction = ins;
			pc = pc + 12'd2;
			x = ins[11:8];
			y = ins[7:4];
			n = ins[3:0];
			kk = ins[7:0];
			nnn = ins[11:0];
			vx = vreg[x];
			vy = vreg[y];
			case (ins[15:12])
				4'h0: begin
					if (ins == bvm_pkg::INS_CLS) begin
						for (int k = 0; k < 2048; k++) pix[k] = 0;
					end else if (ins == bvm_pkg::INS_RET) begin
						sp = sp - 4'd1;
						pc = ret_stack[sp];
					end else r.unknown_instruction = 1;
				end
				4'h1: pc = nnn;
				4'h2: begin
					ret_stack[sp] = pc;
					sp = sp + 4'd1;
					pc = nnn;
				end
				4'h3: if (vx == kk) pc = pc + 12'd2;
				4'h4: if (vx != kk) pc = pc + 12'd2;
				4'h5: if (vx == vy) pc = pc + 12'd2;
				4'h6: vreg[x] = kk;
				4'h7: vreg[x] = vx + kk;
				4'h8: begin
					case (n)
						bvm_pkg::N_LD: vreg[x] = vy;
						bvm_pkg::N_OR: vreg[x] = vx | vy;
						bvm_pkg::N_AND: vreg[x] = vx & vy;
						bvm_pkg::N_XOR: vreg[x] = vx ^ vy;
						bvm_pkg::N_ADD: begin
							f = {7'd0, ({1'b0, vx} + {1'b0, vy}) > 9'hff};
							vreg[x] = vx + vy;
							vreg[bvm_pkg::VF_IDX] = f;
						end
						bvm_pkg::N_SUB: begin
							f = {7'd0, vx > vy};
							vreg[x] = vx - vy;
							vreg[bvm_pkg::VF_IDX] = f;
						end
						bvm_pkg::N_SHR: begin
							f = {7'd0, vx[0]};
							vreg[x] = vx >> 1;
							vreg[bvm_pkg::VF_IDX] = f;
						end
						bvm_pkg::N_SUBN: begin
							f = {7'd0, vy > vx};
							vreg[x] = vy - vx;
							vreg[bvm_pkg::VF_IDX] = f;
						end
						bvm_pkg::N_SHL: begin
							f = {7'd0, vx[7]};
							vreg[x] = vx << 1;
							vreg[bvm_pkg::VF_IDX] = f;
						end
						default: r.unknown_instruction = 1;
					endcase
				end
				4'h9: if (vx != vy) pc = pc + 12'd2;
				4'hA: ireg = {4'h0, nnn};
				4'hB: pc = nnn + {4'h0, vreg[0]};
				4'hC: vreg[x] = c.random_byte & kk;
				4'hD: begin
					hit = 0;
					for (int rr = 0; rr < n; rr++) begin
						bits = mem[12'(ireg + rr)];
						for (int cc = 0; cc < 8; cc++) begin
							if (bits[7 - cc]) begin
								px = (vx % 64 + cc) % 64;
								py = (vy % 32 + rr) % 32;
								if (pix[py * 64 + px]) hit = 1;
								pix[py * 64 + px] ^= 1'b1;
							end
						end
					end
					vreg[bvm_pkg::VF_IDX] = {7'd0, hit};
					r.sprite_collision = hit;
				end
				4'hE: begin
					if (kk == bvm_pkg::KK_SKP) begin
						if (c.key_states[vx[3:0]]) pc = pc + 12'd2;
					end else if (kk == bvm_pkg::KK_SKNP) begin
						if (!c.key_states[vx[3:0]]) pc = pc + 12'd2;
					end else r.unknown_instruction = 1;
				end
				default: begin
					case (kk)
						bvm_pkg::KK_LDDT: vreg[x] = dtimer;
						bvm_pkg::KK_WKEY: begin
							if (c.key_states == 0) begin
								pc = pc - 12'd2;
								r.key_wait = 1;
							end else begin
								for (int k = 15; k >= 0; k--)
									if (c.key_states[k]) vreg[x] = 8'(k);
							end
						end
						bvm_pkg::KK_STDT: dtimer = vx;
						bvm_pkg::KK_STST: stimer = vx;
						bvm_pkg::KK_ADDI: ireg = ireg + {8'h00, vx};
						bvm_pkg::KK_FONT: ireg = 16'(FONT_AT + 5 * vx[3:0]);
						bvm_pkg::KK_BCD: begin
							mem[ireg[11:0]] = 8'(vx / 100);
							mem[12'(ireg + 1)] = 8'((vx / 10) % 10);
							mem[12'(ireg + 2)] = 8'(vx % 10);
						end
						bvm_pkg::KK_STOR:
							for (int k = 0; k <= x; k++) mem[12'(ireg + k)] = vreg[k];
						bvm_pkg::KK_LOAD:
							for (int k = 0; k <= x; k++) vreg[k] = mem[12'(ireg + k)];
						default: r.unknown_instruction = 1;
					endcase
				end
			endcase
			if (dtimer != 0) dtimer--;
			if (stimer != 0) stimer--;
		end
		r.program_counter = pc;
		r.sound_on = stimer != 0;
		return r;
	endfunction

	// driver: present the head of the queue, move on only after it was taken
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_ch.valid <= 1'b0;
			cmd_ch.payload <= '0;
		end else if (!cmd_ch.valid || req_acc) begin
			// the monitor drops the head of the queue at its handshake
			if (pending_reqs.size() > 0 && !hold_send
					&& $urandom_range(99, 0) >= send_idle_pct) begin
				cmd_ch.payload <= pending_reqs[0];
				cmd_ch.valid <= 1'b1;
			end else begin
				cmd_ch.valid <= 1'b0;
			end
		end
	end

	// receiver stall
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) rsp_ch.ready <= 1'b0;
		else rsp_ch.ready <= $urandom_range(99, 0) >= recv_idle_pct;
	end

	// monitor: predict on accepted requests, check accepted results
	always @(posedge clk) begin
		bvm_pkg::rsp_t e;
		req_acc <= arst_n && cmd_ch.valid && cmd_ch.ready;
		if (arst_n) begin
			cycles++;
			if (cmd_ch.valid && cmd_ch.ready) begin
				expected_rsps.push_back(vm_step(cmd_ch.payload));
				if (pending_reqs.size() > 0) pending_reqs.pop_front();
				sent++;
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				checked++;
				if (expected_rsps.size() == 0) begin
					report("unexpected result", 16'h0, 16'h0);
				end else begin
					e = expected_rsps.pop_front();
					if (rsp_ch.payload.program_counter !== e.program_counter)
						report("program_counter", rsp_ch.payload.program_counter, e.program_counter);
					if (rsp_ch.payload.executed_instruction !== e.executed_instruction)
						report("executed_instruction", rsp_ch.payload.executed_instruction,
							e.executed_instruction);
					if (rsp_ch.payload.read_data !== e.read_data)
						report("read_data", rsp_ch.payload.read_data, e.read_data);
					if (rsp_ch.payload.key_wait !== e.key_wait)
						report("key_wait", rsp_ch.payload.key_wait, e.key_wait);
					if (rsp_ch.payload.sprite_collision !== e.sprite_collision)
						report("sprite_collision", rsp_ch.payload.sprite_collision,
							e.sprite_collision);
					if (rsp_ch.payload.sound_on !== e.sound_on)
						report("sound_on", rsp_ch.payload.sound_on, e.sound_on);
					if (rsp_ch.payload.unknown_instruction !== e.unknown_instruction)
						report("unknown_instruction", rsp_ch.payload.unknown_instruction,
							e.unknown_instruction);
				end
			end
		end
	end

	function automatic bvm_pkg::cmd_t make_req(input logic [1:0] op, input logic [11:0] a,
			input logic [7:0] d, input logic [15:0] keys);
		bvm_pkg::cmd_t c;
		c.opcode = op;
		c.address = a;
		c.data = d;
		c.key_states = keys;
		c.random_byte = 8'($urandom);
		return c;
	endfunction

	// shadow of the program counter and stack depth used while generating
	logic [11:0] gen_pc;
	int          gen_depth;

	// place an instruction at the generator's pc and execute it
	task automatic put_exec(input logic [15:0] ins, input logic [15:0] keys);
		pending_reqs.push_back(make_req(bvm_pkg::OP_WRITE, gen_pc, ins[15:8], 16'($urandom)));
		pending_reqs.push_back(make_req(bvm_pkg::OP_WRITE, 12'(gen_pc + 1), ins[7:0],
			16'($urandom)));
		pending_reqs.push_back(make_req(bvm_pkg::OP_EXEC, 12'($urandom), 8'($urandom), keys));
	endtask

	// random instruction that never returns through an unwritten stack slot
	function automatic logic [15:0] rand_ins();
		logic [15:0] ins;
		int pick;
		ins = 16'($urandom);
		pick = $urandom_range(19, 0);
		case (pick)
			0: ins = (gen_depth > 0) ? bvm_pkg::INS_RET : bvm_pkg::INS_CLS;
			1: ins = {4'h8, ins[11:4], bvm_pkg::N_ADD};
			2: ins = {4'h8, ins[11:4], bvm_pkg::N_SUB};
			3: ins = {4'h8, ins[11:4], bvm_pkg::N_SUBN};
			4: ins = {4'h8, ins[11:4], bvm_pkg::N_SHL};
			5: ins = {4'hD, ins[11:4], 4'($urandom_range(15, 0))};
			6: ins = {4'hF, ins[11:8], bvm_pkg::KK_WKEY};
			7: ins = {4'hF, ins[11:8], bvm_pkg::KK_BCD};
			8: ins = {4'hF, ins[11:8], bvm_pkg::KK_STOR};
			9: ins = {4'hF, ins[11:8], bvm_pkg::KK_LOAD};
			10: ins = {4'hF, ins[11:8], bvm_pkg::KK_FONT};
			11: ins = {4'hF, ins[11:8],
				($urandom_range(1, 0)) ? bvm_pkg::KK_STDT : bvm_pkg::KK_STST};
			12: ins = {4'hF, ins[11:8],
				($urandom_range(1, 0)) ? bvm_pkg::KK_LDDT : bvm_pkg::KK_ADDI};
			13: ins = {4'hE, ins[11:8],
				($urandom_range(1, 0)) ? bvm_pkg::KK_SKP : bvm_pkg::KK_SKNP};
			14: ins = {4'hA, ins[11:0]};
			15: ins = {4'h6, ins[11:0]};
			default: ;
		endcase
		// a return with an empty stack would read an unwritten slot
		if (ins[15:12] == 4'h0 && ins[11:0] == bvm_pkg::INS_RET[11:0] && gen_depth == 0)
			ins = bvm_pkg::INS_CLS;
		return ins;
	endfunction

	// The generator cannot know the next pc before the predictor has run, so each
	// instruction is executed right after being placed and the generator waits for
	// its result to learn the new pc.
	task automatic run_ins(input logic [15:0] ins, input logic [15:0] keys);
		put_exec(ins, keys);
		wait (pending_reqs.size() == 0 && expected_rsps.size() == 0);
		@(posedge clk);
		gen_pc = pc;
		if (ins[15:12] == 4'h2) gen_depth = (gen_depth < 16) ? gen_depth + 1 : 16;
		if (ins == bvm_pkg::INS_RET) gen_depth--;
	endtask

	task automatic phase(input int count);
		logic [15:0] ins;
		int r;
		for (int k = 0; k < count; k++) begin
			r = $urandom_range(99, 0);
			if (r < 8) begin
				pending_reqs.push_back(make_req(bvm_pkg::OP_READ, 12'($urandom), 8'($urandom),
					16'($urandom)));
			end else if (r < 12) begin
				pending_reqs.push_back(make_req(bvm_pkg::OP_WRITE,
					12'($urandom_range(4095, 768)), 8'($urandom), 16'($urandom)));
			end else if (r < 14) begin
				pending_reqs.push_back(make_req(bvm_pkg::OP_UNUSED, 12'($urandom),
					8'($urandom), 16'($urandom)));
			end else begin
				ins = rand_ins();
				// keep calls and jumps inside the loadable program area mostly
				if (ins[15:12] inside {4'h1, 4'h2, 4'hB} && $urandom_range(3, 0) != 0)
					ins[11:0] = 12'($urandom_range(4094, 0));
				if (ins[15:12] == 4'h2 && gen_depth >= 15) ins = {4'h1, ins[11:0]};
				run_ins(ins, ($urandom_range(3, 0) == 0) ? 16'h0 : 16'($urandom));
			end
			if (pending_reqs.size() > 6)
				wait (pending_reqs.size() == 0);
		end
		wait (pending_reqs.size() == 0 && expected_rsps.size() == 0);
	endtask

	// stimulus
	initial begin
		errors = 0;
		checked = 0;
		cycles = 0;
		sent = 0;
		hold_send = 0;
		stim_done = 0;
		send_idle_pct = 37;
		recv_idle_pct = 87;
		cmd_ch.valid = 1'b0;
		cmd_ch.payload = '0;
		rsp_ch.ready = 1'b0;
		vm_reset();
		gen_pc = PROG_AT;
		gen_depth = 0;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: extremes, font reads, display reads, unused opcode, key wait, flags
		pending_reqs.push_back(make_req(bvm_pkg::OP_READ, FONT_AT, 8'h00, 16'h0));
		pending_reqs.push_back(make_req(bvm_pkg::OP_READ, 12'hFFF, 8'hFF, 16'hFFFF));
		pending_reqs.push_back(make_req(bvm_pkg::OP_UNUSED, 12'hABC, 8'h55, 16'h1234));
		pending_reqs.push_back(make_req(bvm_pkg::OP_WRITE, 12'hFFF, 8'hFF, 16'h0));
		pending_reqs.push_back(make_req(bvm_pkg::OP_READ, 12'h7FF, 8'h0, 16'h0));
		run_ins(16'h6FFF, 16'h0);
		run_ins(16'h60C8, 16'h0);
		run_ins(16'h8F04, 16'h0);
		run_ins(16'h8F05, 16'h0);
		run_ins(16'h8F07, 16'h0);
		run_ins(16'h8F0E, 16'h0);
		run_ins(16'h8F06, 16'h0);
		run_ins(16'h8008, 16'h0);
		run_ins(16'hF00A, 16'h0);
		run_ins(16'hF30A, 16'h8000);
		run_ins(16'hF029, 16'h0);
		run_ins(16'hD005, 16'h0);
		run_ins(16'hD005, 16'h0);
		run_ins(16'hD3F0, 16'h0);
		pending_reqs.push_back(make_req(bvm_pkg::OP_READ, 12'h800, 8'h0, 16'h0));
		run_ins(16'h6BFF, 16'h0);
		run_ins(16'hFB18, 16'h0);
		run_ins(16'h00E0, 16'h0);
		run_ins(16'hE19E, 16'hFFFF);
		run_ins(16'hE1A1, 16'h0000);
		run_ins(16'h0123, 16'h0);

		phase(230);
		send_idle_pct = 87;
		recv_idle_pct = 37;
		// hold the sender until all results are back
		hold_send = 1;
		wait (expected_rsps.size() == 0);
		repeat (40) @(posedge clk);
		hold_send = 0;
		phase(230);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		phase(230);
		repeat (300) @(posedge clk);
		stim_done = 1;
	end

	// end of run and watchdog
	initial begin
		wait (stim_done || cycles >= CYC_MAX);
		if (cycles >= CYC_MAX) begin
			$display("bytecode_vm_instruction_core_unit_tb: errors");
			$finish;
		end else begin
			$display("covered %0d requests and %0d checked results: loads, reads,", sent, checked);
			$display("all instruction groups, draws, key waits and timers under varied stalls");
			if (errors == 0 && expected_rsps.size() == 0)
				$display("bytecode_vm_instruction_core_unit_tb: clean");
			else
				$display("bytecode_vm_instruction_core_unit_tb: errors");
			$finish;
		end
	end

endmodule
`default_nettype wire
